@@ hw/rtl/greedy_overlap_layer_assigner_macros.svh @@
// Assertion macros used by the checker file of the layer assigner.
`ifndef GREEDY_OVERLAP_LAYER_ASSIGNER_MACROS_SVH
`define GREEDY_OVERLAP_LAYER_ASSIGNER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define GOLA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define GOLA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/gola_pkg.sv @@
// Shared constants of the greedy overlap layer assigner.
package gola_pkg;

    // Default grid and coordinate sizes
    localparam int unsigned MAX_LAYERS_DEF = 16;
    localparam int unsigned MAX_SLOTS_DEF  = 16;
    localparam int unsigned COORD_BITS_DEF = 16;

    // Port field widths
    localparam int unsigned IN_W  = 16;
    localparam int unsigned IDX_W = 4;
    localparam int unsigned CNT_W = 5;

endpackage

@@ hw/rtl/greedy_overlap_layer_assigner.sv @@
// Top level of the greedy overlap layer assigner: sequencer, grid state, output register.
//
//   channel | handshake            | payload
//   --------+----------------------+----------------------------------------------------
//   input   | in_valid / in_ready  | center_x, center_y, box_width, box_height
//   output  | out_valid / out_ready| placed_layer, placed_slot, layers_used,
//           |                      | slots_per_layer, status
//
// The scan issues one box-store read per cycle, and the single overlap unit checks the
// returned box in the cycle after its read is issued. in_ready is high only while idle;
// a finished result waits in the output register, and the next request is accepted
// meanwhile but waits at its write-back for it. Reset clears the grid valid bits and
// both counts at once; no clearing pass.
module greedy_overlap_layer_assigner #(
    parameter int unsigned MAX_LAYERS = gola_pkg::MAX_LAYERS_DEF,
    parameter int unsigned MAX_SLOTS  = gola_pkg::MAX_SLOTS_DEF,
    parameter int unsigned COORD_BITS = gola_pkg::COORD_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic signed [gola_pkg::IN_W-1:0]   center_x,
    input  logic signed [gola_pkg::IN_W-1:0]   center_y,
    input  logic        [gola_pkg::IN_W-1:0]   box_width,
    input  logic        [gola_pkg::IN_W-1:0]   box_height,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic        [gola_pkg::IDX_W-1:0]  placed_layer,
    output logic        [gola_pkg::IDX_W-1:0]  placed_slot,
    output logic        [gola_pkg::CNT_W-1:0]  layers_used,
    output logic        [gola_pkg::CNT_W-1:0]  slots_per_layer,
    output logic                               status
);
    import gola_pkg::*;

    localparam int unsigned CB     = COORD_BITS;
    localparam int unsigned GRID   = MAX_LAYERS * MAX_SLOTS;
    localparam int unsigned LW     = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
    localparam int unsigned SW     = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int unsigned AW     = (GRID > 1) ? $clog2(GRID) : 1;
    localparam int unsigned CNT_LW = $clog2(MAX_LAYERS + 1);
    localparam int unsigned CNT_SW = $clog2(MAX_SLOTS + 1);
    localparam logic [AW-1:0]     MS_A   = AW'(MAX_SLOTS);
    localparam logic [CNT_LW-1:0] ML_CNT = CNT_LW'(MAX_LAYERS);
    localparam logic [CNT_SW-1:0] MS_CNT = CNT_SW'(MAX_SLOTS);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SCAN  = 3'b010,
        ST_PLACE = 3'b100
    } state_t;

    typedef enum logic [1:0] {
        ACT_FILL,
        ACT_WIDEN,
        ACT_NEW,
        ACT_DROP
    } act_t;

    // Control state
    state_t              state_reg,     state_next;
    act_t                act_reg,       act_next;
    logic [LW-1:0]       lay_reg,       lay_next;
    logic [CNT_SW-1:0]   slot_reg,      slot_next;
    logic                pend_reg,      pend_next;
    logic                emp_found_reg, emp_found_next;
    logic [CNT_LW-1:0]   total_reg,     total_next;
    logic [CNT_SW-1:0]   width_reg,     width_next;
    logic [GRID-1:0]     valid_reg;
    logic                out_valid_reg, out_valid_next;

    // Payload registers
    logic [4*CB-1:0]     nb_reg,        nb_next;
    logic [SW-1:0]       emp_slot_reg,  emp_slot_next;
    logic [SW-1:0]       tgt_slot_reg,  tgt_slot_next;
    logic [IDX_W-1:0]    placed_layer_reg;
    logic [IDX_W-1:0]    placed_slot_reg;
    logic [CNT_W-1:0]    layers_used_reg;
    logic [CNT_W-1:0]    slots_per_layer_reg;
    logic                status_reg;

    logic [CB-1:0]       cx_in, cy_in, w_in, h_in;
    logic [4*CB-1:0]     box_in;
    logic [AW-1:0]       scan_addr;
    logic [AW-1:0]       wr_addr;
    logic [4*CB-1:0]     rd_box;
    logic                ovl_hit;
    logic                mem_we;
    logic                fin_ok;
    logic [31:0]         lay32, slot32, tot32, wid32;

    // Input fields read at the coordinate width
    if (COORD_BITS <= IN_W)
    begin : g_narrow
        assign cx_in = center_x[CB-1:0];
        assign cy_in = center_y[CB-1:0];
        assign w_in  = box_width[CB-1:0];
        assign h_in  = box_height[CB-1:0];
    end
    else
    begin : g_wide
        assign cx_in = {{(CB-IN_W){1'b0}}, center_x};
        assign cy_in = {{(CB-IN_W){1'b0}}, center_y};
        assign w_in  = {{(CB-IN_W){1'b0}}, box_width};
        assign h_in  = {{(CB-IN_W){1'b0}}, box_height};
    end

    assign box_in = {cx_in, cy_in, w_in, h_in};

    // Grid addresses: layer * MAX_SLOTS + slot
    assign scan_addr = AW'(lay_reg) * MS_A + AW'(slot_reg[SW-1:0]);
    assign wr_addr   = AW'(lay_reg) * MS_A + AW'(tgt_slot_reg);

    assign fin_ok   = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == ST_IDLE);

    gola_mem #(
        .DEPTH (GRID),
        .AW    (AW),
        .DW    (4 * CB)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (wr_addr),
        .wdata (nb_reg),
        .raddr (scan_addr),
        .rdata (rd_box)
    );

    gola_ovl #(
        .COORD_BITS (CB)
    ) u_ovl (
        .box_a (rd_box),
        .box_b (nb_reg),
        .hit   (ovl_hit)
    );

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        act_next       = act_reg;
        lay_next       = lay_reg;
        slot_next      = slot_reg;
        pend_next      = pend_reg;
        emp_found_next = emp_found_reg;
        emp_slot_next  = emp_slot_reg;
        tgt_slot_next  = tgt_slot_reg;
        total_next     = total_reg;
        width_next     = width_reg;
        nb_next        = nb_reg;
        mem_we         = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    nb_next        = box_in;
                    lay_next       = '0;
                    slot_next      = '0;
                    pend_next      = 1'b0;
                    emp_found_next = 1'b0;
                    if (total_reg == '0)
                    begin
                        // empty grid: open layer 0 at once
                        act_next      = ACT_NEW;
                        tgt_slot_next = '0;
                        state_next    = ST_PLACE;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                if (pend_reg && ovl_hit)
                begin
                    // clash in this layer
                    if (CNT_LW'(lay_reg) + CNT_LW'(1) == total_reg)
                    begin
                        if (total_reg >= ML_CNT)
                        begin
                            act_next = ACT_DROP;
                        end
                        else
                        begin
                            act_next      = ACT_NEW;
                            lay_next      = total_reg[LW-1:0];
                            tgt_slot_next = '0;
                        end
                        state_next = ST_PLACE;
                    end
                    else
                    begin
                        lay_next       = lay_reg + LW'(1);
                        slot_next      = '0;
                        pend_next      = 1'b0;
                        emp_found_next = 1'b0;
                    end
                end
                else if (slot_reg < width_reg)
                begin
                    // issue the next slot; note the first empty one
                    slot_next = slot_reg + CNT_SW'(1);
                    pend_next = valid_reg[scan_addr];
                    if (!valid_reg[scan_addr] && !emp_found_reg)
                    begin
                        emp_found_next = 1'b1;
                        emp_slot_next  = slot_reg[SW-1:0];
                    end
                end
                else
                begin
                    // layer accepted the box
                    if (emp_found_reg)
                    begin
                        act_next      = ACT_FILL;
                        tgt_slot_next = emp_slot_reg;
                    end
                    else if (width_reg < MS_CNT)
                    begin
                        act_next      = ACT_WIDEN;
                        tgt_slot_next = width_reg[SW-1:0];
                    end
                    else
                    begin
                        act_next = ACT_DROP;
                    end
                    state_next = ST_PLACE;
                end
            end

            ST_PLACE:
            begin
                if (fin_ok)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                    case (act_reg)
                        ACT_FILL:
                        begin
                            mem_we = 1'b1;
                        end
                        ACT_WIDEN:
                        begin
                            mem_we     = 1'b1;
                            width_next = width_reg + CNT_SW'(1);
                        end
                        ACT_NEW:
                        begin
                            mem_we     = 1'b1;
                            total_next = total_reg + CNT_LW'(1);
                            if (width_reg == '0)
                            begin
                                width_next = CNT_SW'(1);
                            end
                        end
                        default:
                        begin
                            mem_we = 1'b0;
                        end
                    endcase
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Result fields masked to port widths
    assign lay32  = 32'(lay_reg);
    assign slot32 = 32'(tgt_slot_reg);
    assign tot32  = 32'(total_next);
    assign wid32  = 32'(width_next);

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            act_reg       <= ACT_FILL;
            lay_reg       <= '0;
            slot_reg      <= '0;
            pend_reg      <= 1'b0;
            emp_found_reg <= 1'b0;
            total_reg     <= '0;
            width_reg     <= '0;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            act_reg       <= act_next;
            lay_reg       <= lay_next;
            slot_reg      <= slot_next;
            pend_reg      <= pend_next;
            emp_found_reg <= emp_found_next;
            total_reg     <= total_next;
            width_reg     <= width_next;
            out_valid_reg <= out_valid_next;
            if (mem_we)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        nb_reg       <= nb_next;
        emp_slot_reg <= emp_slot_next;
        tgt_slot_reg <= tgt_slot_next;
        if (state_reg == ST_PLACE && fin_ok)
        begin
            if (act_reg == ACT_DROP)
            begin
                placed_layer_reg <= '0;
                placed_slot_reg  <= '0;
                status_reg       <= 1'b1;
            end
            else
            begin
                placed_layer_reg <= lay32[IDX_W-1:0];
                placed_slot_reg  <= slot32[IDX_W-1:0];
                status_reg       <= 1'b0;
            end
            layers_used_reg     <= tot32[CNT_W-1:0];
            slots_per_layer_reg <= wid32[CNT_W-1:0];
        end
    end

    assign out_valid       = out_valid_reg;
    assign placed_layer    = placed_layer_reg;
    assign placed_slot     = placed_slot_reg;
    assign layers_used     = layers_used_reg;
    assign slots_per_layer = slots_per_layer_reg;
    assign status          = status_reg;

endmodule

@@ hw/rtl/gola_ovl.sv @@
// Shared overlap compare unit: strict center-distance test on both axes.
module gola_ovl #(
    parameter int unsigned COORD_BITS = 16
) (
    input  logic [4*COORD_BITS-1:0] box_a,
    input  logic [4*COORD_BITS-1:0] box_b,
    output logic                    hit
);
    localparam int unsigned CB = COORD_BITS;

    logic signed [CB:0]   dx;
    logic signed [CB:0]   dy;
    logic        [CB:0]   adx;
    logic        [CB:0]   ady;
    logic        [CB:0]   wsum;
    logic        [CB:0]   hsum;
    logic                 x_hit;
    logic                 y_hit;

    // Field order in a packed box: cx, cy, w, h (cx on top)
    assign dx = $signed({box_a[4*CB-1], box_a[4*CB-1:3*CB]})
              - $signed({box_b[4*CB-1], box_b[4*CB-1:3*CB]});
    assign dy = $signed({box_a[3*CB-1], box_a[3*CB-1:2*CB]})
              - $signed({box_b[3*CB-1], box_b[3*CB-1:2*CB]});

    // Magnitudes fit CB+1 unsigned bits
    assign adx = dx[CB] ? $unsigned(-dx) : $unsigned(dx);
    assign ady = dy[CB] ? $unsigned(-dy) : $unsigned(dy);

    // Summed extents
    assign wsum = {1'b0, box_a[2*CB-1:CB]} + {1'b0, box_b[2*CB-1:CB]};
    assign hsum = {1'b0, box_a[CB-1:0]}    + {1'b0, box_b[CB-1:0]};

    // 2|d| < sum, both axes strictly
    assign x_hit = {adx, 1'b0} < {1'b0, wsum};
    assign y_hit = {ady, 1'b0} < {1'b0, hsum};
    assign hit   = x_hit && y_hit;

endmodule

@@ hw/rtl/gola_mem.sv @@
// Box store: one write port, one read port with registered read data.
module gola_mem #(
    parameter int unsigned DEPTH = 256,
    parameter int unsigned AW    = 8,
    parameter int unsigned DW    = 64
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);
    logic [DW-1:0] box_mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            box_mem[waddr] <= wdata;
        end
        rd_data_reg <= box_mem[raddr];
    end

    assign rdata = rd_data_reg;

endmodule

@@ hw/rtl/gola_chk.sv @@
// Port-level checker for the layer assigner and its bind to the top level.
`include "greedy_overlap_layer_assigner_macros.svh"

module gola_chk #(
    parameter int unsigned MAX_LAYERS = gola_pkg::MAX_LAYERS_DEF,
    parameter int unsigned MAX_SLOTS  = gola_pkg::MAX_SLOTS_DEF
) (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_ready,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic [gola_pkg::IDX_W-1:0]        placed_layer,
    input logic [gola_pkg::IDX_W-1:0]        placed_slot,
    input logic [gola_pkg::CNT_W-1:0]        layers_used,
    input logic [gola_pkg::CNT_W-1:0]        slots_per_layer,
    input logic                              status
);
    import gola_pkg::*;

    localparam logic SMALL_GRID = (MAX_LAYERS <= 16) && (MAX_SLOTS <= 16);

    // A stalled result holds its layer, slot and status
    `GOLA_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(placed_layer) && $stable(placed_slot) && $stable(status), "result changed while stalled")

    // The block is busy right after taking a request
    `GOLA_ASSERT_NXT(a_busy_after_req, in_valid && in_ready, !in_ready, "ready right after a request")

    // A dropped box reports layer and slot zero
    `GOLA_ASSERT_IMP(a_drop_zero, out_valid && status, placed_layer == '0 && placed_slot == '0, "dropped box with nonzero position")

    // A placed box lies inside the reported grid (checked only for grids up to 16 by 16)
    `GOLA_ASSERT_IMP(a_in_grid, out_valid && !status && SMALL_GRID, CNT_W'(placed_layer) < layers_used && CNT_W'(placed_slot) < slots_per_layer, "placed box outside the grid")

endmodule

bind greedy_overlap_layer_assigner gola_chk #(
    .MAX_LAYERS (MAX_LAYERS),
    .MAX_SLOTS  (MAX_SLOTS)
) u_gola_chk (.*);

@@ tb/tb_greedy_overlap_layer_assigner.sv @@
// Testbench for the greedy overlap layer assigner: directed and random boxes vs. a predictor.
module tb_greedy_overlap_layer_assigner;
    timeunit 1ns;
    timeprecision 1ps;

    import gola_pkg::*;

    localparam int N_LAYERS    = MAX_LAYERS_DEF;
    localparam int N_SLOTS     = MAX_SLOTS_DEF;
    localparam int GRID_CELLS  = N_LAYERS * N_SLOTS;
    localparam int SCAN_CYCLES = 2 + N_LAYERS * (N_SLOTS + 1);
    localparam int CYCLE_LIMIT = 4_000_000;

    localparam logic STATUS_PLACED  = 1'b0;
    localparam logic STATUS_DROPPED = 1'b1;

    typedef struct packed {
        logic [IN_W-1:0] cx;
        logic [IN_W-1:0] cy;
        logic [IN_W-1:0] w;
        logic [IN_W-1:0] h;
    } box_t;

    typedef struct {
        logic [IDX_W-1:0] layer;
        logic [IDX_W-1:0] slot;
        logic [CNT_W-1:0] layers;
        logic [CNT_W-1:0] slots;
        logic             dropped;
    } placement_t;

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_ready;
    logic signed [IN_W-1:0]  center_x;
    logic signed [IN_W-1:0]  center_y;
    logic        [IN_W-1:0]  box_width;
    logic        [IN_W-1:0]  box_height;
    logic                    out_valid;
    logic                    out_ready;
    logic        [IDX_W-1:0] placed_layer;
    logic        [IDX_W-1:0] placed_slot;
    logic        [CNT_W-1:0] layers_used;
    logic        [CNT_W-1:0] slots_per_layer;
    logic                    status;

    // Predicted grid contents
    box_t       grid_box  [GRID_CELLS];
    bit         grid_used [GRID_CELLS];
    int         layer_count = 0;
    int         slot_count  = 0;
    int         placed_cells[$];
    placement_t expected_placements[$];

    int idle_pct    = 0;
    int stall_pct   = 0;
    int error_count = 0;
    int cycle_count = 0;

    greedy_overlap_layer_assigner dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .center_x        (center_x),
        .center_y        (center_y),
        .box_width       (box_width),
        .box_height      (box_height),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .placed_layer    (placed_layer),
        .placed_slot     (placed_slot),
        .layers_used     (layers_used),
        .slots_per_layer (slots_per_layer),
        .status          (status)
    );

    always #5 clk = ~clk;

    // Strict overlap test on both axes
    function automatic bit boxes_clash(box_t a, box_t b);
        int ax;
        int bx;
        int ay;
        int by;
        int dx;
        int dy;
        ax = $signed(a.cx);
        bx = $signed(b.cx);
        ay = $signed(a.cy);
        by = $signed(b.cy);
        dx = ax - bx;
        dy = ay - by;
        if (dx < 0)
            dx = -dx;
        if (dy < 0)
            dy = -dy;
        return (2 * dx < int'(a.w) + int'(b.w)) && (2 * dy < int'(a.h) + int'(b.h));
    endfunction

    function automatic void store_box(int l, int s, box_t b);
        grid_box[l * N_SLOTS + s]  = b;
        grid_used[l * N_SLOTS + s] = 1'b1;
        placed_cells.push_back(l * N_SLOTS + s);
    endfunction

    function automatic placement_t outcome(int l, int s, logic stat);
        placement_t r;
        r.layer   = l[IDX_W-1:0];
        r.slot    = s[IDX_W-1:0];
        r.layers  = layer_count[CNT_W-1:0];
        r.slots   = slot_count[CNT_W-1:0];
        r.dropped = stat;
        return r;
    endfunction

    // First clear layer takes the box; widen or open a layer when needed, else drop it
    function automatic placement_t place_box(box_t b);
        bit clash;
        int s;
        for (int l = 0; l < layer_count; l++)
        begin
            clash = 1'b0;
            for (s = 0; s < slot_count; s++)
                if (grid_used[l * N_SLOTS + s] && boxes_clash(grid_box[l * N_SLOTS + s], b))
                    clash = 1'b1;
            if (!clash)
            begin
                for (s = 0; s < slot_count; s++)
                    if (!grid_used[l * N_SLOTS + s])
                    begin
                        store_box(l, s, b);
                        return outcome(l, s, STATUS_PLACED);
                    end
                // chosen layer is full: widen all layers, unless already at the width limit
                if (slot_count >= N_SLOTS)
                    return outcome(0, 0, STATUS_DROPPED);
                slot_count++;
                store_box(l, slot_count - 1, b);
                return outcome(l, slot_count - 1, STATUS_PLACED);
            end
        end
        if (layer_count >= N_LAYERS)
            return outcome(0, 0, STATUS_DROPPED);
        layer_count++;
        if (slot_count == 0)
            slot_count = 1;
        store_box(layer_count - 1, 0, b);
        return outcome(layer_count - 1, 0, STATUS_PLACED);
    endfunction

    function automatic box_t make_box(int x, int y, int w, int h);
        box_t b;
        b.cx = x[IN_W-1:0];
        b.cy = y[IN_W-1:0];
        b.w  = w[IN_W-1:0];
        b.h  = h[IN_W-1:0];
        return b;
    endfunction

    function automatic logic [IN_W-1:0] corner_value();
        case ($urandom_range(4))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'h8000;
            3: return 16'h7FFF;
            default: return IN_W'($urandom);
        endcase
    endfunction

    // Mix: small scattered boxes, boxes next to stored ones, full-range noise, corners
    function automatic box_t random_box();
        box_t b;
        box_t near_box;
        int   pick;
        pick = $urandom_range(99);
        b.cx = IN_W'($urandom);
        b.cy = IN_W'($urandom);
        b.w  = IN_W'($urandom_range(64));
        b.h  = IN_W'($urandom_range(64));
        if (pick >= 90)
        begin
            b.cx = corner_value();
            b.cy = corner_value();
            b.w  = corner_value();
            b.h  = corner_value();
        end
        else if (pick >= 75)
        begin
            b.w = IN_W'($urandom);
            b.h = IN_W'($urandom);
        end
        else if (pick >= 45 && placed_cells.size() != 0)
        begin
            near_box = grid_box[placed_cells[$urandom_range(placed_cells.size() - 1)]];
            b.cx = IN_W'(near_box.cx + $urandom_range(64) - 32);
            b.cy = IN_W'(near_box.cy + $urandom_range(64) - 32);
            b.w  = IN_W'($urandom_range(128));
            b.h  = IN_W'($urandom_range(128));
        end
        return b;
    endfunction

    // Send one request and record its predicted placement on acceptance
    task automatic send_box(box_t b);
        @(negedge clk);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid   = 1'b1;
        center_x   = b.cx;
        center_y   = b.cy;
        box_width  = b.w;
        box_height = b.h;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        expected_placements.push_back(place_box(b));
    endtask

    task automatic test_first_box();
        send_box(make_box(0, 0, 10, 10));
    endtask

    // Widening, new layer on overlap, touching edges, clash found only in the last slot
    task automatic test_widen_and_overlap();
        send_box(make_box(100, 0, 10, 10));
        send_box(make_box(5, 0, 10, 10));
        send_box(make_box(110, 0, 10, 10));
        send_box(make_box(100, 10, 10, 10));
        send_box(make_box(101, 11, 4, 4));
    endtask

    // Zero extent: inside a covering box it overlaps, two coincident points do not
    task automatic test_degenerate_boxes();
        send_box(make_box(0, 0, 0, 0));
        send_box(make_box(300, 300, 0, 0));
        send_box(make_box(300, 300, 0, 0));
        send_box(make_box(300, 300, 2, 0));
    endtask

    task automatic test_coordinate_extremes();
        send_box(make_box(-32768, -32768, 65535, 65535));
        send_box(make_box(32767, 32767, 65535, 65535));
        send_box(make_box(32767, -32768, 0, 65535));
        send_box(make_box(-32768, 32767, 65535, 0));
    endtask

    // Fill layer 0 until the width is at its limit, then one more clear box is dropped
    task automatic test_widening_limit();
        int i;
        i = 0;
        send_box(make_box(20000, 20000, 40, 40));
        while (slot_count < N_SLOTS && i < 24)
        begin
            send_box(make_box(-30000 + i * 2500, -30000, 4, 4));
            i++;
        end
        send_box(make_box(-30000, 30000, 4, 4));
    endtask

    // Stack boxes on one spot until every layer is open, then one more is dropped
    task automatic test_layer_limit();
        int i;
        i = 0;
        while (layer_count < N_LAYERS && i < 40)
        begin
            send_box(make_box(20000, 20000, 40, 40));
            i++;
        end
        send_box(make_box(20000, 20000, 40, 40));
    endtask

    task automatic test_random_traffic(int count, int idle, int stall);
        idle_pct  = idle;
        stall_pct = stall;
        repeat (count)
            send_box(random_box());
    endtask

    // Receiver back-pressure
    always @(negedge clk)
        out_ready = ($urandom_range(99) >= stall_pct);

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            error_count++;
        end
    endfunction

    // Compare each result with the oldest predicted placement
    always @(posedge clk)
    begin : result_check
        placement_t want;
        if (rst_n && out_valid === 1'b1 && out_ready)
        begin
            if (expected_placements.size() == 0)
            begin
                $error("unexpected result: layer %0d slot %0d", placed_layer, placed_slot);
                error_count++;
            end
            else
            begin
                want = expected_placements.pop_front();
                check_field("placed_layer", 32'(want.layer), 32'(placed_layer));
                check_field("placed_slot", 32'(want.slot), 32'(placed_slot));
                check_field("layers_used", 32'(want.layers), 32'(layers_used));
                check_field("slots_per_layer", 32'(want.slots), 32'(slots_per_layer));
                check_field("status", 32'(want.dropped), 32'(status));
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        out_ready  = 1'b0;
        center_x   = '0;
        center_y   = '0;
        box_width  = '0;
        box_height = '0;
        for (int k = 0; k < GRID_CELLS; k++)
            grid_used[k] = 1'b0;
        repeat (8)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_first_box();
        test_widen_and_overlap();
        test_degenerate_boxes();
        test_coordinate_extremes();
        test_widening_limit();
        test_layer_limit();
        test_random_traffic(400, 0, 0);
        test_random_traffic(400, 63, 0);
        test_random_traffic(400, 0, 63);
        test_random_traffic(400, 34, 34);

        @(negedge clk);
        in_valid = 1'b0;

        // drain outstanding results, then watch for strays
        while (expected_placements.size() != 0)
            @(posedge clk);
        repeat (SCAN_CYCLES + 16)
            @(posedge clk);

        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
